@@ hdl/bitmap_priority_run_queue_defines.svh @@
// Assertion macros shared by the checker of the run queue block.
// No dependencies.
`ifndef BITMAP_PRIORITY_RUN_QUEUE_DEFINES_SVH
`define BITMAP_PRIORITY_RUN_QUEUE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BPRQ_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("bprq check failed");
// next-cycle implication
`define BPRQ_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("bprq check failed");
`endif

@@ hdl/bprq_pkg.sv @@
// Package for the run queue block: opcodes, status codes and field widths.
// No dependencies.
`default_nettype none
package bprq_pkg;
  localparam int unsigned OP_ADD    = 0;
  localparam int unsigned OP_REMOVE = 1;
  localparam int unsigned OP_MOVE   = 2;
  localparam int unsigned OP_PICK   = 3;
  localparam int unsigned OP_PICK_G = 4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // input beat fields
  typedef struct packed {
    logic       use_expired;
    logic [2:0] group;
    logic [4:0] priority_req;
    logic [7:0] thread_id;
    logic [2:0] opcode;
  } req_t;

  // result beat fields
  typedef struct packed {
    logic [8:0] expired_count;
    logic [8:0] active_count;
    logic       queues_swapped;
    logic [2:0] picked_group;
    logic [4:0] picked_priority;
    logic [7:0] picked_thread;
    logic [1:0] status;
  } rsp_t;
endpackage
`default_nettype wire

@@ hdl/bprq_find.sv @@
// Lowest-set-bit finder used for priority and group selection.
// Depends on nothing.
`default_nettype none
module bprq_find #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0]         vec_i,
  output logic [$clog2(W)-1:0] idx_o
);
  // priority encode from bit 0 up
  always_comb begin
    idx_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = i[$clog2(W)-1:0];
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/bitmap_priority_run_queue.sv @@
// Each beat runs through a sequencer that walks the link and bucket memories one
// read-modify-write at a time (a move of a thread in the middle of its list takes longest;
// a rejected request takes the shortest path).
// Throughput: one beat at a time; the next beat is taken once the result beat has left.
// Reset: control, bitmaps, counts and per-thread valid flags clear at once; the link,
// bucket and placement memories hold no reset and are only read for entries written.
`default_nettype none
module bitmap_priority_run_queue #(
  parameter int unsigned NUM_PRIORITIES = 32,
  parameter int unsigned NUM_GROUPS     = 8,
  parameter int unsigned NUM_THREADS    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], thread_id[10:3], priority_req[15:11], group[18:16], use_expired[19]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], picked_thread[9:2], picked_priority[14:10], picked_group[17:15],
  // queues_swapped[18], active_count[27:19], expired_count[36:28]
  output logic [39:0] m_axis_tdata
);
  import bprq_pkg::*;

  localparam int unsigned PW = $clog2(NUM_PRIORITIES);
  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned TW = $clog2(NUM_THREADS);
  localparam int unsigned BW = 1 + PW + GW;
  localparam int unsigned NB = 1 << BW;
  localparam int unsigned CW = TW + 1;
  localparam int unsigned LW = 1 + PW + GW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PICK, S_DQ_RD, S_DQ_WAIT, S_DQ_UPD, S_DQ_MID,
    S_ENQ_RD, S_ENQ_WAIT, S_ENQ_UPD, S_DONE
  } state_e;

  // link and bucket memories
  logic [TW-1:0] next_mem [NUM_THREADS];
  logic [TW-1:0] prev_mem [NUM_THREADS];
  logic [TW-1:0] head_mem [NB];
  logic [TW-1:0] tail_mem [NB];

  // per-thread valid flags with reset; queue, priority and group in a memory
  logic [NUM_THREADS-1:0] pv_q;
  logic [LW-1:0]          place_mem [NUM_THREADS];
  logic [LW-1:0]          place_rd_q;
  logic [TW-1:0]          place_addr;
  logic                   pl_q;
  logic [PW-1:0]          pl_p;
  logic [GW-1:0]          pl_g;

  logic [NUM_GROUPS-1:0]     gbm_q [2][NUM_PRIORITIES];
  logic [NUM_PRIORITIES-1:0] pbm_q [2];
  logic [NUM_PRIORITIES-1:0] gpb_q [2][NUM_GROUPS];
  logic [CW-1:0]             tot_q [2];
  logic                      act_q;

  state_e        state_q;
  req_t          req_q;
  rsp_t          rsp_q;
  logic          out_v_q;
  logic [TW-1:0] t_q;
  logic          q_q;
  logic [PW-1:0] p_q;
  logic [GW-1:0] g_q;
  logic          enq_after_q;
  logic          is_head_q, is_tail_q;
  logic [TW-1:0] head_rd_q, tail_rd_q, nxt_rd_q, prv_rd_q;
  logic [TW-1:0] mid_p_q, mid_n_q;

  req_t req_in;
  assign req_in = req_t'(s_axis_tdata[19:0]);

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, rsp_q};

  // pick selection on the active queue (after a possible swap)
  logic          a_sel;
  logic [PW-1:0] best_p, grp_p;
  logic [GW-1:0] best_g;
  assign a_sel = act_q;
  bprq_find #(.W(NUM_PRIORITIES)) u_fp (.vec_i(pbm_q[a_sel]), .idx_o(best_p));
  bprq_find #(.W(NUM_GROUPS)) u_fg (.vec_i(gbm_q[a_sel][best_p]), .idx_o(best_g));
  logic [GW-1:0] want_g;
  logic          want_ok;
  assign want_g  = req_q.group[GW-1:0];
  assign want_ok = ({5'd0, req_q.group} < NUM_GROUPS) && (gpb_q[a_sel][want_g] != '0);
  bprq_find #(.W(NUM_PRIORITIES)) u_fgp (.vec_i(gpb_q[a_sel][want_g]), .idx_o(grp_p));

  logic [BW-1:0] bkt;
  assign bkt = {q_q, p_q, g_q};

  // memory read ports, registered
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bkt];
    tail_rd_q <= tail_mem[bkt];
    nxt_rd_q  <= next_mem[t_q];
    prv_rd_q  <= prev_mem[t_q];
  end

  // placement memory: read at the accepting edge, written when a thread is linked
  assign place_addr = s_axis_tready ? req_in.thread_id[TW-1:0] : t_q;
  assign {pl_q, pl_p, pl_g} = place_rd_q;

  always_ff @(posedge clk_i) begin
    place_rd_q <= place_mem[place_addr];
    if (state_q == S_ENQ_UPD) place_mem[t_q] <= {q_q, p_q, g_q};
  end

  // sequencer: walks the bucket and link memories through decode, dequeue and enqueue steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      pv_q    <= '0;
      act_q   <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        pbm_q[k] <= '0;
        tot_q[k] <= '0;
        for (int i = 0; i < NUM_PRIORITIES; i++) gbm_q[k][i] <= '0;
        for (int i = 0; i < NUM_GROUPS; i++) gpb_q[k][i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            req_q       <= req_in;
            t_q         <= req_in.thread_id[TW-1:0];
            rsp_q       <= '0;
            enq_after_q <= 1'b0;
            state_q     <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (32'(req_q.opcode))
            OP_ADD: begin
              if ({1'b0, req_q.thread_id} >= 9'(NUM_THREADS) ||
                  {2'b0, req_q.priority_req} >= 7'(NUM_PRIORITIES) ||
                  {5'b0, req_q.group} >= 8'(NUM_GROUPS) || pv_q[t_q]) begin
                rsp_q.status <= ST_BAD;
                state_q <= S_DONE;
              end else begin
                q_q <= act_q ^ req_q.use_expired;
                p_q <= req_q.priority_req[PW-1:0];
                g_q <= req_q.group[GW-1:0];
                state_q <= S_ENQ_RD;
              end
            end
            OP_REMOVE, OP_MOVE: begin
              if ({1'b0, req_q.thread_id} >= 9'(NUM_THREADS) || !pv_q[t_q] ||
                  pl_q != (act_q ^ req_q.use_expired)) begin
                rsp_q.status <= ST_BAD;
                state_q <= S_DONE;
              end else begin
                q_q <= pl_q;
                p_q <= pl_p;
                g_q <= pl_g;
                enq_after_q <= (32'(req_q.opcode) == OP_MOVE);
                state_q <= S_DQ_RD;
              end
            end
            OP_PICK, OP_PICK_G: begin
              if (pbm_q[act_q] == '0) begin
                act_q <= ~act_q;
                rsp_q.queues_swapped <= 1'b1;
              end
              state_q <= S_PICK;
            end
            default: begin
              rsp_q.status <= ST_BAD;
              state_q <= S_DONE;
            end
          endcase
        end
        S_PICK: begin
          if (pbm_q[a_sel] == '0) begin
            rsp_q.status <= ST_EMPTY;
            state_q <= S_DONE;
          end else begin
            q_q <= a_sel;
            if (32'(req_q.opcode) == OP_PICK_G && want_ok) begin
              p_q <= grp_p;
              g_q <= want_g;
            end else begin
              p_q <= best_p;
              g_q <= best_g;
            end
            state_q <= S_DQ_RD;
          end
        end
        S_DQ_RD: begin
          // bucket address settles; head read lands next cycle
          state_q <= S_DQ_WAIT;
        end
        S_DQ_WAIT: begin
          if (32'(req_q.opcode) == OP_PICK || 32'(req_q.opcode) == OP_PICK_G) begin
            // head thread becomes the target; reread links for it
            t_q <= head_rd_q;
            rsp_q.picked_thread   <= 8'(head_rd_q);
            rsp_q.picked_priority <= 5'(p_q);
            rsp_q.picked_group    <= 3'(g_q);
            req_q.opcode <= 3'(OP_REMOVE);
            state_q <= S_DQ_RD;
          end else begin
            is_head_q <= (head_rd_q == t_q);
            is_tail_q <= (tail_rd_q == t_q);
            state_q <= S_DQ_UPD;
          end
        end
        S_DQ_UPD: begin
          if (is_head_q && is_tail_q) begin
            gbm_q[q_q][p_q][g_q] <= 1'b0;
            gpb_q[q_q][g_q][p_q] <= 1'b0;
            if ((gbm_q[q_q][p_q] & ~(NUM_GROUPS'(1) << g_q)) == '0)
              pbm_q[q_q][p_q] <= 1'b0;
          end else if (is_head_q) begin
            head_mem[bkt] <= nxt_rd_q;
          end else if (is_tail_q) begin
            tail_mem[bkt] <= prv_rd_q;
          end else begin
            next_mem[prv_rd_q] <= nxt_rd_q;
            mid_p_q <= prv_rd_q;
            mid_n_q <= nxt_rd_q;
          end
          tot_q[q_q] <= tot_q[q_q] - 1'b1;
          pv_q[t_q] <= 1'b0;
          if (!is_head_q && !is_tail_q) state_q <= S_DQ_MID;
          else if (enq_after_q) begin
            q_q <= ~q_q;
            state_q <= S_ENQ_RD;
          end else state_q <= S_DONE;
        end
        S_DQ_MID: begin
          prev_mem[mid_n_q] <= mid_p_q;
          if (enq_after_q) begin
            q_q <= ~q_q;
            state_q <= S_ENQ_RD;
          end else state_q <= S_DONE;
        end
        S_ENQ_RD: state_q <= S_ENQ_WAIT;
        S_ENQ_WAIT: state_q <= S_ENQ_UPD;
        S_ENQ_UPD: begin
          if (gbm_q[q_q][p_q][g_q]) begin
            next_mem[tail_rd_q] <= t_q;
            prev_mem[t_q] <= tail_rd_q;
          end else begin
            head_mem[bkt] <= t_q;
          end
          tail_mem[bkt] <= t_q;
          gbm_q[q_q][p_q][g_q] <= 1'b1;
          pbm_q[q_q][p_q] <= 1'b1;
          gpb_q[q_q][g_q][p_q] <= 1'b1;
          tot_q[q_q] <= tot_q[q_q] + 1'b1;
          pv_q[t_q] <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_v_q || m_axis_tready) begin
            rsp_q.active_count  <= 9'(tot_q[act_q]);
            rsp_q.expired_count <= 9'(tot_q[~act_q]);
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (out_v_q && m_axis_tready && !(state_q == S_DONE)) out_v_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hdl/bprq_checker.sv @@
// Port-level checker for the run queue block, bound to the top level.
// Depends on bprq_pkg and the assertion macro header.
`default_nettype none
`include "bitmap_priority_run_queue_defines.svh"
module bprq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import bprq_pkg::*;
  // a result beat that stalls keeps its payload
  `BPRQ_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // status is never the unused code
  `BPRQ_ASSERT_IMP(a_status, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  // one beat at a time: no input taken in the cycle after one was taken
  `BPRQ_ASSERT_NXT(a_seq, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a failed request reports no picked thread
  `BPRQ_ASSERT_IMP(a_badpick, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK,
    m_axis_tdata[9:2] == 8'd0)
endmodule
bind bitmap_priority_run_queue bprq_checker u_bprq_checker (.*);
`default_nettype wire

@@ tb/run_queue_checker.sv @@
// Checker for the run queue block: watches both stream channels, predicts each result
// with its own scheduler model and compares field by field. Depends on bprq_pkg.
`default_nettype none
module run_queue_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import bprq_pkg::*;

  // per-thread placement and per-bucket FIFOs, kept as plain queues
  bit          queued_q [256];
  bit          queue_of [256];
  bit   [4:0]  prio_of  [256];
  bit   [2:0]  group_of [256];
  logic [7:0]  bucket_fifo [2][32][8][$];
  int unsigned total_q [2];
  bit          active_sel;
  rsp_t        rsp_fifo [$];

  task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic int unsigned pos_of(input logic [7:0] t);
    for (int i = 0; i < bucket_fifo[queue_of[t]][prio_of[t]][group_of[t]].size(); i++)
      if (bucket_fifo[queue_of[t]][prio_of[t]][group_of[t]][i] == t) return i;
    return 0;
  endfunction

  function automatic void unlink(input logic [7:0] t);
    bucket_fifo[queue_of[t]][prio_of[t]][group_of[t]].delete(pos_of(t));
    total_q[queue_of[t]]--;
    queued_q[t] = 0;
  endfunction

  function automatic void link(input logic [7:0] t, input bit q, input bit [4:0] p,
                               input bit [2:0] g);
    bucket_fifo[q][p][g].push_back(t);
    queued_q[t] = 1; queue_of[t] = q; prio_of[t] = p; group_of[t] = g;
    total_q[q]++;
  endfunction

  function automatic bit queue_empty(input bit q);
    return total_q[q] == 0;
  endfunction

  // model one request, return its expected result
  function automatic rsp_t schedule(input req_t r);
    rsp_t o;
    bit   q;
    int   bp, bg;
    o = '0;
    q = active_sel ^ r.use_expired;
    case (r.opcode)
      OP_ADD: begin
        if (queued_q[r.thread_id]) o.status = ST_BAD;
        else link(r.thread_id, q, r.priority_req, r.group);
      end
      OP_REMOVE, OP_MOVE: begin
        if (!queued_q[r.thread_id] || queue_of[r.thread_id] != q) begin
          o.status = ST_BAD;
        end else begin
          bit [4:0] p;
          bit [2:0] g;
          p = prio_of[r.thread_id];
          g = group_of[r.thread_id];
          unlink(r.thread_id);
          if (r.opcode == OP_MOVE) link(r.thread_id, !q, p, g);
        end
      end
      OP_PICK, OP_PICK_G: begin
        if (queue_empty(active_sel)) begin
          active_sel = !active_sel;
          o.queues_swapped = 1;
        end
        if (queue_empty(active_sel)) begin
          o.status = ST_EMPTY;
        end else begin
          bp = -1; bg = -1;
          // wanted group first, lowest priority number wins
          if (r.opcode == OP_PICK_G)
            for (int p = 0; p < 32 && bp < 0; p++)
              if (bucket_fifo[active_sel][p][r.group].size() != 0) begin
                bp = p; bg = r.group;
              end
          for (int p = 0; p < 32 && bp < 0; p++)
            for (int g = 0; g < 8 && bp < 0; g++)
              if (bucket_fifo[active_sel][p][g].size() != 0) begin
                bp = p; bg = g;
              end
          o.picked_thread   = bucket_fifo[active_sel][bp][bg][0];
          o.picked_priority = 5'(bp);
          o.picked_group    = 3'(bg);
          unlink(o.picked_thread);
        end
      end
      default: o.status = ST_BAD;
    endcase
    o.active_count  = 9'(total_q[active_sel]);
    o.expired_count = 9'(total_q[!active_sel]);
    return o;
  endfunction

  assign pending_o = rsp_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      active_sel = 0;
      total_q = '{0, 0};
      foreach (queued_q[i]) queued_q[i] = 0;
      foreach (bucket_fifo[a, b, c]) bucket_fifo[a][b][c].delete();
      rsp_fifo.delete();
    end else begin
      // compare result beat against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        rsp_t got, want;
        got = m_axis_tdata[36:0];
        if (rsp_fifo.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = rsp_fifo.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.picked_thread != want.picked_thread)
            report("picked_thread", got.picked_thread, want.picked_thread);
          if (got.picked_priority != want.picked_priority)
            report("picked_priority", got.picked_priority, want.picked_priority);
          if (got.picked_group != want.picked_group)
            report("picked_group", got.picked_group, want.picked_group);
          if (got.queues_swapped != want.queues_swapped)
            report("queues_swapped", got.queues_swapped, want.queues_swapped);
          if (got.active_count != want.active_count)
            report("active_count", got.active_count, want.active_count);
          if (got.expired_count != want.expired_count)
            report("expired_count", got.expired_count, want.expired_count);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rsp_fifo.push_back(schedule(s_axis_tdata[19:0]));
    end
  end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Stimulus top for the run queue block: clock, reset, request beats and result stalls.
// Depends on bprq_pkg, bitmap_priority_run_queue and run_queue_checker.
`default_nettype none
module testbench;
  import bprq_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          hold_cnt;
  int          draw;
  bit          busy_sender;
  bit          no_gaps;

  bitmap_priority_run_queue u_top (.*);

  run_queue_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // send one request beat after a random gap (none while no_gaps is set)
  task automatic send(input logic [2:0] op, input logic [7:0] t, input logic [4:0] p,
                      input logic [2:0] g, input logic ue);
    int gap;
    req_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    r = '{use_expired: ue, group: g, priority_req: p, thread_id: t, opcode: op};
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {4'b0, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // result side: after each result beat, hold ready low for a randomly drawn stall (none while no_gaps is set)
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      draw = no_gaps ? 0 : $urandom_range(0, 6);
      hold_cnt      <= draw;
      m_axis_tready <= (draw == 0);
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      hold_cnt      <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] pool [$];
    int kind;
    cycle_count   = 0;
    no_gaps       = 0;
    rst_ni        = 0;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty picks, field extremes, bad requests, every opcode
    send(OP_PICK, 0, 0, 0, 0);
    send(OP_PICK_G, 0, 0, 7, 0);
    send(OP_ADD, 8'd255, 5'd31, 3'd7, 0);
    send(OP_ADD, 8'd0, 5'd0, 3'd0, 0);
    send(OP_ADD, 8'd0, 5'd3, 3'd1, 1);
    send(OP_ADD, 8'd170, 5'd0, 3'd0, 0);
    send(OP_ADD, 8'd85, 5'd0, 3'd0, 0);
    send(OP_ADD, 8'd17, 5'd10, 3'd5, 1);
    send(OP_REMOVE, 8'd170, 0, 0, 0);
    send(OP_REMOVE, 8'd17, 0, 0, 0);
    send(OP_MOVE, 8'd99, 0, 0, 0);
    send(OP_MOVE, 8'd255, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0);
    send(3'd6, 0, 0, 0, 1);
    send(3'd7, 8'd255, 5'd31, 3'd7, 1);
    send(OP_PICK_G, 0, 0, 3'd7, 1);
    send(OP_PICK_G, 0, 0, 3'd2, 0);
    send(OP_PICK, 0, 0, 0, 0);
    send(OP_PICK, 0, 0, 0, 0);
    send(OP_PICK, 0, 0, 0, 0);
    send(OP_PICK, 0, 0, 0, 0);
    // hold off until the block has drained
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    // random: adds mostly from a small id pool so removes and moves hit queued threads
    for (int i = 0; i < 650; i++) begin
      if (i == 300) no_gaps = 1;
      if (i == 380) no_gaps = 0;
      kind = $urandom_range(0, 99);
      if (kind < 40)
        send(OP_ADD, (kind < 35) ? $urandom_range(0, 31) : $urandom_range(0, 255),
             $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 1));
      else if (kind < 55)
        send(OP_REMOVE, $urandom_range(0, 31), 0, 0, $urandom_range(0, 1));
      else if (kind < 67)
        send(OP_MOVE, $urandom_range(0, 31), 0, 0, $urandom_range(0, 1));
      else if (kind < 80)
        send(OP_PICK, $urandom, $urandom, $urandom, $urandom);
      else if (kind < 95)
        send(OP_PICK_G, $urandom, $urandom, $urandom, $urandom);
      else
        send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
    end
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ bitmap_priority_run_queue.f @@
+incdir+hdl
hdl/bprq_pkg.sv
hdl/bprq_find.sv
hdl/bitmap_priority_run_queue.sv
hdl/bprq_checker.sv
tb/run_queue_checker.sv
tb/testbench.sv
